// ===== src/lcb_pkg.sv =====
// Shared constants, types, microcode table and digit helpers for the card check block.
package lcb_pkg;

    localparam int MAX_DIGITS    = 19;
    localparam int DIGIT_SLOTS   = 20;
    localparam int CARD_W        = 64;
    localparam int BCD_W         = 4 * DIGIT_SLOTS;
    localparam int BITS_PER_STEP = 2;
    localparam int DABBLE_STEPS  = CARD_W / BITS_PER_STEP;
    localparam int CNT_W         = 5;
    localparam int LOOP_W        = 5;
    localparam int PC_W          = 2;
    localparam int VISA_MIN_LEN  = 12;

    localparam logic [1:0] BRAND_INVALID    = 2'd0;
    localparam logic [1:0] BRAND_AMEX       = 2'd1;
    localparam logic [1:0] BRAND_MASTERCARD = 2'd2;
    localparam logic [1:0] BRAND_VISA       = 2'd3;

    localparam logic [PC_W-1:0] PC_IDLE   = 2'd0;
    localparam logic [PC_W-1:0] PC_DABBLE = 2'd1;
    localparam logic [PC_W-1:0] PC_SCAN   = 2'd2;
    localparam logic [PC_W-1:0] PC_EMIT   = 2'd3;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_DABBLE = 2'd1,
        OP_SCAN   = 2'd2,
        OP_EMIT   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        COND_IDLE   = 2'd0,
        COND_LOOP   = 2'd1,
        COND_ALWAYS = 2'd2
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [PC_W-1:0]  target;
        logic             loop_ld;
        logic [LOOP_W-1:0] loop_val;
    } t_uword;

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword uw;
        uw = '{op: OP_LOAD, cond: COND_ALWAYS, target: PC_IDLE, loop_ld: 1'b0, loop_val: '0};
        case (pc)
            PC_IDLE: begin
                uw = '{op: OP_LOAD, cond: COND_IDLE, target: PC_IDLE, loop_ld: 1'b1,
                       loop_val: LOOP_W'(DABBLE_STEPS - 1)};
            end
            PC_DABBLE: begin
                uw = '{op: OP_DABBLE, cond: COND_LOOP, target: PC_DABBLE, loop_ld: 1'b1,
                       loop_val: LOOP_W'(DIGIT_SLOTS - 1)};
            end
            PC_SCAN: begin
                uw = '{op: OP_SCAN, cond: COND_LOOP, target: PC_SCAN, loop_ld: 1'b0,
                       loop_val: '0};
            end
            PC_EMIT: begin
                uw = '{op: OP_EMIT, cond: COND_ALWAYS, target: PC_IDLE, loop_ld: 1'b0,
                       loop_val: '0};
            end
            default: begin
                uw = '{op: OP_LOAD, cond: COND_ALWAYS, target: PC_IDLE, loop_ld: 1'b0,
                       loop_val: '0};
            end
        endcase
        return uw;
    endfunction

    function automatic logic [BCD_W-1:0] dabble_bit(input logic [BCD_W-1:0] bcd,
                                                    input logic b);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int k = 0; k < DIGIT_SLOTS; k++) begin
            if (bcd[4*k +: 4] >= 4'd5) begin
                adj[4*k +: 4] = bcd[4*k +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], b};
    endfunction

    function automatic logic [3:0] luhn_dbl(input logic [3:0] d);
        logic [3:0] r;
        case (d)
            4'd0:    r = 4'd0;
            4'd1:    r = 4'd2;
            4'd2:    r = 4'd4;
            4'd3:    r = 4'd6;
            4'd4:    r = 4'd8;
            4'd5:    r = 4'd1;
            4'd6:    r = 4'd3;
            4'd7:    r = 4'd5;
            4'd8:    r = 4'd7;
            4'd9:    r = 4'd9;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== src/luhn_card_brand_check_top.sv =====
// Top level of the Luhn checksum and card brand check.
// A card number is taken when start is high and busy is low. Each number goes
// from acceptance to result through one load step, 32 conversion steps of two
// bits each into decimal digits, 20 digit steps for the Luhn sum and count, and
// one decode step, all run by the microcode sequencer. The result is on the
// output ports for one cycle while o_valid is high and must be taken then; busy
// falls in that same cycle, so the next word may be started alongside it.
module luhn_card_brand_check_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [lcb_pkg::CARD_W-1:0]  i_card_number,
    output logic [1:0]                  o_brand,
    output logic                        o_checksum_ok,
    output logic [lcb_pkg::CNT_W-1:0]   o_digit_total,
    output logic                        o_valid
);
    import lcb_pkg::*;

    t_op op;

    lcb_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_op    (op)
    );

    lcb_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (op),
        .i_card_number (i_card_number),
        .o_brand       (o_brand),
        .o_checksum_ok (o_checksum_ok),
        .o_digit_total (o_digit_total),
        .o_valid       (o_valid)
    );

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_brand_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_brand != BRAND_INVALID)) |-> o_checksum_ok)
        else $error("brand reported with failed checksum");

    a_visa_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_brand == BRAND_VISA)) |-> (o_digit_total > CNT_W'(VISA_MIN_LEN)))
        else $error("visa reported for short number");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digit_total <= CNT_W'(DIGIT_SLOTS)))
        else $error("digit count out of range");

endmodule

// ===== src/lcb_seq.sv =====
// Microcode sequencer: step counter, loop counter and conditional jumps.
module lcb_seq (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    output lcb_pkg::t_op o_op
);
    import lcb_pkg::*;

    logic [PC_W-1:0]   r_pc;
    logic [PC_W-1:0]   n_pc;
    logic [LOOP_W-1:0] r_loop;
    logic [LOOP_W-1:0] n_loop;
    t_uword            uw;
    logic              taken;

    always_comb begin
        uw = ucode(r_pc);
        case (uw.cond)
            COND_IDLE:   taken = !start;
            COND_LOOP:   taken = (r_loop != '0);
            COND_ALWAYS: taken = 1'b1;
            default:     taken = 1'b1;
        endcase
        n_loop = r_loop;
        if (taken) begin
            n_pc = uw.target;
            if (uw.cond == COND_LOOP) begin
                n_loop = r_loop - LOOP_W'(1);
            end
        end else begin
            n_pc = r_pc + PC_W'(1);
            if (uw.loop_ld) begin
                n_loop = uw.loop_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= PC_IDLE;
            r_loop <= '0;
        end else begin
            r_pc   <= n_pc;
            r_loop <= n_loop;
        end
    end

    assign busy = (r_pc != PC_IDLE);
    assign o_op = uw.op;

endmodule

// ===== src/lcb_dp.sv =====
// Datapath: binary to decimal conversion, digit scan, Luhn sum and brand decode.
module lcb_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lcb_pkg::t_op                i_op,
    input  logic [lcb_pkg::CARD_W-1:0]  i_card_number,
    output logic [1:0]                  o_brand,
    output logic                        o_checksum_ok,
    output logic [lcb_pkg::CNT_W-1:0]   o_digit_total,
    output logic                        o_valid
);
    import lcb_pkg::*;

    logic [CARD_W-1:0] r_bin;
    logic [BCD_W-1:0]  r_bcd;
    logic [CNT_W-1:0]  r_idx;
    logic [3:0]        r_sum;
    logic [CNT_W-1:0]  r_cnt;
    logic [3:0]        r_lead;
    logic [3:0]        r_next;
    logic              r_two;
    logic [3:0]        r_prev;
    logic [1:0]        r_brand;
    logic              r_ok;
    logic [CNT_W-1:0]  r_total;
    logic              r_valid;

    logic [BCD_W-1:0]  n_bcd;
    logic [3:0]        dig;
    logic [3:0]        dval;
    logic [4:0]        sum5;
    logic [3:0]        n_sum;
    logic              over;
    logic              ok;
    logic              amex;
    logic              mc;
    logic              visa;
    logic [1:0]        n_brand;

    always_comb begin
        n_bcd = dabble_bit(dabble_bit(r_bcd, r_bin[CARD_W-1]), r_bin[CARD_W-2]);
        dig   = r_bcd[3:0];
        dval  = r_idx[0] ? luhn_dbl(dig) : dig;
        sum5  = {1'b0, r_sum} + {1'b0, dval};
        n_sum = (sum5 >= 5'd10) ? 4'(sum5 - 5'd10) : sum5[3:0];
        over  = (r_cnt > CNT_W'(MAX_DIGITS));
        ok    = !over && (r_sum == 4'd0);
        amex  = r_two && (r_lead == 4'd3) && ((r_next == 4'd4) || (r_next == 4'd7));
        mc    = r_two && (r_lead == 4'd5) && (r_next >= 4'd1) && (r_next <= 4'd5);
        visa  = (r_lead == 4'd4) && (r_cnt > CNT_W'(VISA_MIN_LEN));
        if (!ok) begin
            n_brand = BRAND_INVALID;
        end else if (amex) begin
            n_brand = BRAND_AMEX;
        end else if (mc) begin
            n_brand = BRAND_MASTERCARD;
        end else if (visa) begin
            n_brand = BRAND_VISA;
        end else begin
            n_brand = BRAND_INVALID;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_bin  <= i_card_number;
                r_bcd  <= '0;
                r_idx  <= '0;
                r_sum  <= '0;
                r_cnt  <= '0;
                r_lead <= '0;
                r_next <= '0;
                r_two  <= 1'b0;
                r_prev <= '0;
            end
            OP_DABBLE: begin
                r_bcd <= n_bcd;
                r_bin <= {r_bin[CARD_W-BITS_PER_STEP-1:0], BITS_PER_STEP'(0)};
            end
            OP_SCAN: begin
                r_bcd  <= {4'd0, r_bcd[BCD_W-1:4]};
                r_idx  <= r_idx + CNT_W'(1);
                r_sum  <= n_sum;
                r_prev <= dig;
                if (dig != 4'd0) begin
                    r_cnt  <= r_idx + CNT_W'(1);
                    r_lead <= dig;
                    r_next <= r_prev;
                    r_two  <= (r_idx != '0);
                end
            end
            OP_EMIT: begin
                r_brand <= n_brand;
                r_ok    <= ok;
                r_total <= r_cnt;
            end
            default: begin
                r_bin <= r_bin;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_op == OP_EMIT);
        end
    end

    assign o_brand       = r_brand;
    assign o_checksum_ok = r_ok;
    assign o_digit_total = r_total;
    assign o_valid       = r_valid;

endmodule
